@@ hdl/mbg_pkg.sv @@
// ----------------------------------------------------------------------------
// mbg_pkg
// shared types, codes and helper functions of the maze generator
// ----------------------------------------------------------------------------
`default_nettype none

package mbg_pkg;

    localparam int DIM_W  = 6;
    localparam int SEED_W = 16;
    localparam int KIND_W = 2;
    localparam int ORD_W  = 8;
    localparam int IDX_W  = 3;

    localparam logic [DIM_W-1:0]  DIM_RESET = 6'd21;
    localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;

    // cell codes
    localparam logic [KIND_W-1:0] KIND_PATH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WALL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GOAL = 2'd2;

    // operation codes
    localparam logic OP_GEN  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // direction codes
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic sweep_wr;
        logic gen_init;
        logic step;
        logic carve_mid;
        logic push;
        logic pop_rd;
        logic pop_ld;
        logic goal_clr;
        logic goal_wr;
        logic mark;
        logic rd_req;
        logic rd_done;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op;
        logic sweep_last;
        logic exhausted;
        logic top_one;
        logic oob;
        logic cell_wall;
        logic full;
        logic goal_last;
    } sts_t;

    function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] n;
        n = s >> 1;
        if (s[0])
        begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

    // three draws; returns {new lfsr state, order packed 2 bits per entry}
    function automatic logic [SEED_W+ORD_W-1:0] shuffle(input logic [SEED_W-1:0] s);
        logic [1:0]        ord [4];
        logic [SEED_W-1:0] st;
        logic [18:0]       prod;
        logic [1:0]        j;
        logic [1:0]        t;
        ord[0] = 2'd0;
        ord[1] = 2'd1;
        ord[2] = 2'd2;
        ord[3] = 2'd3;
        st = s;
        for (int i = 3; i > 0; i--)
        begin
            st   = lfsr_next(st);
            prod = 19'(st) * 19'(i + 1);
            j    = prod[17:16];
            t      = ord[i];
            ord[i] = ord[j];
            ord[j] = t;
        end
        return {st, ord[3], ord[2], ord[1], ord[0]};
    endfunction

    // even rounds up to odd, then clamp to [3, cap]
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [7:0] cap);
        logic [7:0] e;
        e = {2'b00, v};
        if (!e[0])
        begin
            e = e + 8'd1;
        end
        if (e < 8'd3)
        begin
            e = 8'd3;
        end
        if (e > cap)
        begin
            e = cap;
        end
        return e[DIM_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/mbg_if.sv @@
// ----------------------------------------------------------------------------
// mbg_if
// valid/ready channels for request and response words
// ----------------------------------------------------------------------------
`default_nettype none

interface mbg_req_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [mbg_pkg::SEED_W-1:0]  seed;
    logic [mbg_pkg::DIM_W-1:0]   col;
    logic [mbg_pkg::DIM_W-1:0]   row;

    modport source (output valid, op, seed, col, row, input ready);
    modport sink   (input valid, op, seed, col, row, output ready);
endinterface

interface mbg_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [mbg_pkg::KIND_W-1:0]  cell_kind;
    logic                        outside;

    modport source (output valid, cell_kind, outside, input ready);
    modport sink   (input valid, cell_kind, outside, output ready);
endinterface

`default_nettype wire

@@ hdl/mbg_ram.sv @@
// ----------------------------------------------------------------------------
// mbg_ram
// generic ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mbg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/mbg_ctrl.sv @@
// ----------------------------------------------------------------------------
// mbg_ctrl
// sequencer for clearing, carving, goal marking and cell reads
// ----------------------------------------------------------------------------
`default_nettype none

module mbg_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire mbg_pkg::sts_t sts,
    output mbg_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_REQ,
        ST_RD_WAIT,
        ST_GEN_INIT,
        ST_STEP,
        ST_CHECK,
        ST_CARVE,
        ST_POP_WAIT,
        ST_GOAL,
        ST_MARK,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   gen_reg, gen_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        gen_next       = gen_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep_wr = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = gen_reg ? ST_GEN_INIT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    if (sts.op == mbg_pkg::OP_GEN)
                    begin
                        gen_next   = 1'b1;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_RD_REQ;
                    end
                end
            end
            ST_RD_REQ:
            begin
                cmd.rd_req = 1'b1;
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                cmd.rd_done = 1'b1;
                state_next  = ST_RESULT;
            end
            ST_GEN_INIT:
            begin
                cmd.gen_init = 1'b1;
                gen_next     = 1'b0;
                state_next   = ST_STEP;
            end
            ST_STEP:
            begin
                priority if (sts.exhausted && sts.top_one)
                begin
                    cmd.goal_clr = 1'b1;
                    state_next   = ST_GOAL;
                end
                else if (sts.exhausted)
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = ST_POP_WAIT;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = sts.oob ? ST_STEP : ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.cell_wall && !sts.full)
                begin
                    cmd.carve_mid = 1'b1;
                    state_next    = ST_CARVE;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_CARVE:
            begin
                cmd.push   = 1'b1;
                state_next = ST_STEP;
            end
            ST_POP_WAIT:
            begin
                cmd.pop_ld = 1'b1;
                state_next = ST_STEP;
            end
            ST_GOAL:
            begin
                cmd.goal_wr = 1'b1;
                if (sts.goal_last)
                begin
                    state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                cmd.mark   = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            gen_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ hdl/mbg_dp.sv @@
// ----------------------------------------------------------------------------
// mbg_dp
// grid and stack memories, walk registers, lfsr and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module mbg_dp #(
    parameter int MAX_DIM     = 63,
    parameter int STACK_DEPTH = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_index,
    input  wire logic [mbg_pkg::DIM_W-1:0]         cfg_data,
    input  wire logic                              in_op,
    input  wire logic [mbg_pkg::SEED_W-1:0]        in_seed,
    input  wire logic [mbg_pkg::DIM_W-1:0]         in_col,
    input  wire logic [mbg_pkg::DIM_W-1:0]         in_row,
    output logic      [mbg_pkg::KIND_W-1:0]        out_kind,
    output logic                                   out_outside,
    input  wire mbg_pkg::cmd_t                     cmd,
    output mbg_pkg::sts_t                          sts
);

    localparam int CW     = $clog2(MAX_DIM + 1);
    localparam int AW     = 2 * CW;
    localparam int CMP_W  = (CW + 1 > mbg_pkg::DIM_W) ? CW + 1 : mbg_pkg::DIM_W;
    localparam int FW     = 2 * CW + mbg_pkg::ORD_W + mbg_pkg::IDX_W;
    localparam int SW     = $clog2(STACK_DEPTH);
    localparam int TW     = $clog2(STACK_DEPTH + 1);
    localparam logic [7:0] DIM_CAP = 8'((MAX_DIM - 1) | 1);

    function automatic logic [CW-1:0] to_coord(input logic [mbg_pkg::DIM_W-1:0] v);
        logic [CW+mbg_pkg::DIM_W-1:0] t;
        t = {{CW{1'b0}}, v};
        return t[CW-1:0];
    endfunction

    // config
    logic [mbg_pkg::DIM_W-1:0] w_cfg_reg, h_cfg_reg;
    logic [mbg_pkg::DIM_W-1:0] w_eff, h_eff;

    // walk state
    logic [CW-1:0]               cur_x_reg, cur_y_reg;
    logic [mbg_pkg::ORD_W-1:0]   cur_ord_reg;
    logic [mbg_pkg::IDX_W-1:0]   cur_idx_reg;
    logic [CW-1:0]               nx_reg, ny_reg, mx_reg, my_reg;
    logic [TW-1:0]               top_reg;
    logic [mbg_pkg::SEED_W-1:0]  rng_reg;
    logic [AW-1:0]               sweep_reg;
    logic [1:0]                  gox_reg, goy_reg;

    // read request and results
    logic [CW-1:0]               lat_col_reg, lat_row_reg;
    logic                        lat_out_reg;
    logic [mbg_pkg::KIND_W-1:0]  res_kind_reg, out_kind_reg;
    logic                        res_out_reg, out_out_reg;

    logic [1:0]                  cur_dir;
    logic [CMP_W-1:0]            xe, ye, we_c, he_c;
    logic                        oob;
    logic [CW-1:0]               n_x, n_y, m_x, m_y;
    logic [mbg_pkg::SEED_W+mbg_pkg::ORD_W-1:0] shuf;
    logic [mbg_pkg::DIM_W-1:0]   gx_half, gy_half, gx6, gy6;
    logic [CW-1:0]               gx, gy;
    logic [TW-1:0]               top_m1, top_m2;

    // memory ports
    logic                        g_we, g_re;
    logic [AW-1:0]               g_waddr, g_raddr;
    logic [mbg_pkg::KIND_W-1:0]  g_wdata, g_rdata;
    logic                        s_we, s_re;
    logic [SW-1:0]               s_waddr, s_raddr;
    logic [FW-1:0]               s_wdata, s_rdata;

    assign w_eff = mbg_pkg::eff_dim(w_cfg_reg, DIM_CAP);
    assign h_eff = mbg_pkg::eff_dim(h_cfg_reg, DIM_CAP);

    assign cur_dir = cur_ord_reg[{cur_idx_reg[1:0], 1'b0} +: 2];
    assign xe      = CMP_W'(cur_x_reg);
    assign ye      = CMP_W'(cur_y_reg);
    assign we_c    = CMP_W'(w_eff);
    assign he_c    = CMP_W'(h_eff);

    // neighbor two cells away and the wall cell between
    always_comb
    begin
        n_x = cur_x_reg;
        n_y = cur_y_reg;
        m_x = cur_x_reg;
        m_y = cur_y_reg;
        oob = 1'b0;
        unique case (cur_dir)
            mbg_pkg::DIR_UP:
            begin
                oob = ye < CMP_W'(2);
                n_y = cur_y_reg - CW'(2);
                m_y = cur_y_reg - CW'(1);
            end
            mbg_pkg::DIR_RIGHT:
            begin
                oob = (xe + CMP_W'(2)) >= we_c;
                n_x = cur_x_reg + CW'(2);
                m_x = cur_x_reg + CW'(1);
            end
            mbg_pkg::DIR_DOWN:
            begin
                oob = (ye + CMP_W'(2)) >= he_c;
                n_y = cur_y_reg + CW'(2);
                m_y = cur_y_reg + CW'(1);
            end
            mbg_pkg::DIR_LEFT:
            begin
                oob = xe < CMP_W'(2);
                n_x = cur_x_reg - CW'(2);
                m_x = cur_x_reg - CW'(1);
            end
            default:
            begin
                oob = 1'b1;
            end
        endcase
    end

    assign shuf = mbg_pkg::shuffle(rng_reg);

    // goal cell: half size, forced odd
    assign gx_half = w_eff >> 1;
    assign gy_half = h_eff >> 1;
    assign gx6     = gx_half[0] ? gx_half : gx_half - mbg_pkg::DIM_W'(1);
    assign gy6     = gy_half[0] ? gy_half : gy_half - mbg_pkg::DIM_W'(1);
    assign gx      = to_coord(gx6);
    assign gy      = to_coord(gy6);

    assign top_m1 = top_reg - TW'(1);
    assign top_m2 = top_reg - TW'(2);

    // grid port selection
    always_comb
    begin
        g_we    = 1'b1;
        g_waddr = '0;
        g_wdata = mbg_pkg::KIND_PATH;
        priority if (cmd.sweep_wr)
        begin
            g_waddr = sweep_reg;
            g_wdata = mbg_pkg::KIND_WALL;
        end
        else if (cmd.gen_init)
        begin
            g_waddr = {CW'(1), CW'(1)};
        end
        else if (cmd.carve_mid)
        begin
            g_waddr = {my_reg, mx_reg};
        end
        else if (cmd.push)
        begin
            g_waddr = {ny_reg, nx_reg};
        end
        else if (cmd.goal_wr)
        begin
            g_waddr = {gy + CW'(goy_reg) - CW'(1), gx + CW'(gox_reg) - CW'(1)};
        end
        else if (cmd.mark)
        begin
            g_waddr = {gy, gx};
            g_wdata = mbg_pkg::KIND_GOAL;
        end
        else
        begin
            g_we = 1'b0;
        end
    end

    assign g_re    = cmd.step || cmd.rd_req;
    assign g_raddr = cmd.step ? {n_y, n_x} : {lat_row_reg, lat_col_reg};

    // stack holds every frame below the current one
    assign s_we    = cmd.push;
    assign s_waddr = top_m1[SW-1:0];
    assign s_wdata = {cur_idx_reg, cur_ord_reg, cur_y_reg, cur_x_reg};
    assign s_re    = cmd.pop_rd;
    assign s_raddr = top_m2[SW-1:0];

    mbg_ram #(
        .WIDTH (mbg_pkg::KIND_W),
        .DEPTH (2 ** AW)
    ) u_grid (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .re    (g_re),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    mbg_ram #(
        .WIDTH (FW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_cfg_reg <= mbg_pkg::DIM_RESET;
            h_cfg_reg <= mbg_pkg::DIM_RESET;
            top_reg   <= '0;
            rng_reg   <= mbg_pkg::SEED_W'(1);
            sweep_reg <= '0;
            gox_reg   <= '0;
            goy_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en && cfg_index == mbg_pkg::REG_WIDTH)
            begin
                w_cfg_reg <= cfg_data;
            end
            if (cfg_wr_en && cfg_index == mbg_pkg::REG_HEIGHT)
            begin
                h_cfg_reg <= cfg_data;
            end

            if (cmd.latch_in && in_op == mbg_pkg::OP_GEN)
            begin
                rng_reg   <= (in_seed == '0) ? mbg_pkg::SEED_W'(1) : in_seed;
                sweep_reg <= '0;
            end
            else if (cmd.sweep_wr)
            begin
                sweep_reg <= sweep_reg + AW'(1);
            end

            if (cmd.gen_init || cmd.push)
            begin
                rng_reg <= shuf[mbg_pkg::SEED_W+mbg_pkg::ORD_W-1:mbg_pkg::ORD_W];
            end

            priority if (cmd.gen_init)
            begin
                top_reg <= TW'(1);
            end
            else if (cmd.push)
            begin
                top_reg <= top_reg + TW'(1);
            end
            else if (cmd.pop_ld)
            begin
                top_reg <= top_m1;
            end

            if (cmd.goal_clr)
            begin
                gox_reg <= '0;
                goy_reg <= '0;
            end
            else if (cmd.goal_wr)
            begin
                if (gox_reg == 2'd2)
                begin
                    gox_reg <= '0;
                    goy_reg <= goy_reg + 2'd1;
                end
                else
                begin
                    gox_reg <= gox_reg + 2'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        priority if (cmd.gen_init)
        begin
            cur_x_reg   <= CW'(1);
            cur_y_reg   <= CW'(1);
            cur_ord_reg <= shuf[mbg_pkg::ORD_W-1:0];
            cur_idx_reg <= '0;
        end
        else if (cmd.push)
        begin
            cur_x_reg   <= nx_reg;
            cur_y_reg   <= ny_reg;
            cur_ord_reg <= shuf[mbg_pkg::ORD_W-1:0];
            cur_idx_reg <= '0;
        end
        else if (cmd.pop_ld)
        begin
            {cur_idx_reg, cur_ord_reg, cur_y_reg, cur_x_reg} <= s_rdata;
        end
        else if (cmd.step)
        begin
            cur_idx_reg <= cur_idx_reg + mbg_pkg::IDX_W'(1);
        end

        if (cmd.step)
        begin
            nx_reg <= n_x;
            ny_reg <= n_y;
            mx_reg <= m_x;
            my_reg <= m_y;
        end

        if (cmd.latch_in)
        begin
            lat_col_reg <= to_coord(in_col);
            lat_row_reg <= to_coord(in_row);
            lat_out_reg <= (in_col >= w_eff) || (in_row >= h_eff);
        end

        if (cmd.rd_done)
        begin
            res_kind_reg <= lat_out_reg ? mbg_pkg::KIND_WALL : g_rdata;
            res_out_reg  <= lat_out_reg;
        end
        else if (cmd.mark)
        begin
            res_kind_reg <= mbg_pkg::KIND_PATH;
            res_out_reg  <= 1'b0;
        end

        if (cmd.out_load)
        begin
            out_kind_reg <= res_kind_reg;
            out_out_reg  <= res_out_reg;
        end
    end

    assign out_kind    = out_kind_reg;
    assign out_outside = out_out_reg;

    assign sts.op         = in_op;
    assign sts.sweep_last = &sweep_reg;
    assign sts.exhausted  = cur_idx_reg[2];
    assign sts.top_one    = (top_reg == TW'(1));
    assign sts.oob        = oob;
    assign sts.cell_wall  = (g_rdata == mbg_pkg::KIND_WALL);
    assign sts.full       = (top_reg >= TW'(STACK_DEPTH));
    assign sts.goal_last  = (gox_reg == 2'd2) && (goy_reg == 2'd2);

endmodule

`default_nettype wire

@@ hdl/maze_backtracker_generator.sv @@
// ----------------------------------------------------------------------------
// maze_backtracker_generator
// depth-first maze builder with an explicit walk stack and cell read-back
// ----------------------------------------------------------------------------
// read word: the cell goes from the grid ram to the result register, then the
//   output register; one word in flight at a time
// generate word: sweep of all 2**(2*clog2(MAX_DIM+1)) cells (4096 by default),
//   init at (1,1), directions tried, carve and push, pops, goal clearing, mark
// reset: the grid sweep to all walls runs first (4096 cells by default),
//   no word is accepted until it ends; config writes are taken at any time
// ----------------------------------------------------------------------------
`default_nettype none

module maze_backtracker_generator #(
    parameter int MAX_DIM     = 63,
    parameter int STACK_DEPTH = 1024
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // config registers: index 0 width, index 1 height
    input  wire logic                      cfg_wr_en,
    input  wire logic                      cfg_index,
    input  wire logic [mbg_pkg::DIM_W-1:0] cfg_data,
    // request words in, response words out
    mbg_req_if.sink                        req,
    mbg_rsp_if.source                      rsp
);

    // command and status between sequencer and datapath
    mbg_pkg::cmd_t cmd;
    mbg_pkg::sts_t sts;

    // sequencer: owns handshakes and the word in flight
    mbg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: grid ram, stack ram, walk registers and output register
    mbg_dp #(
        .MAX_DIM     (MAX_DIM),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_op       (req.op),
        .in_seed     (req.seed),
        .in_col      (req.col),
        .in_row      (req.row),
        .out_kind    (rsp.cell_kind),
        .out_outside (rsp.outside),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire
